[rtl/core/psv_pkg.sv]
// Shared types, constants and helpers for the plucked-string voice.
`timescale 1ns / 1ps
package psv_pkg;

    localparam int MAX_DELAY_DEF = 4096;
    localparam int SAMPLE_W      = 16;
    localparam int POS_W         = 12;
    localparam int OP_W          = 2;
    localparam int DLEN_W        = 13;
    localparam int ALPHA_W       = 16;
    localparam int COUNT_W       = 20;
    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = 20;
    localparam int S_TDATA_W     = 32;
    localparam int M_TDATA_W     = 40;

    localparam int MAC_A_W = 19;
    localparam int MAC_B_W = 18;
    localparam int PROD_W  = MAC_A_W + MAC_B_W;
    localparam int ACC_W   = PROD_W + 1;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_PLUCK = 2'd1;
    localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_DELAY_LENGTH    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SMOOTHING_ALPHA = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_NOTE_LENGTH = 2'd2;

    localparam logic [DLEN_W-1:0]  DLEN_RESET  = 13'd100;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd53111;
    localparam logic [COUNT_W-1:0] MAXLEN_RESET = 20'd132300;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 20'hFFFFF;

    // 0.999 in Q0.16
    localparam logic [MAC_B_W-1:0] GAIN_Q16  = 18'd65470;
    localparam logic [MAC_B_W-1:0] UNITY_Q16 = 18'd65536;
    localparam logic [ACC_W-1:0]   MIX_BIAS  = ACC_W'(1 << 17);
    localparam logic [ACC_W-1:0]   FILT_BIAS = ACC_W'(1 << 15);

    typedef struct packed {
        logic mul_en;
        logic acc_clear;
        logic acc_add;
    } psv_mac_ctrl_t;

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
        lo = -hi - ACC_W'(1);
        if (v > hi) begin
            return hi[SAMPLE_W-1:0];
        end else if (v < lo) begin
            return lo[SAMPLE_W-1:0];
        end
        return v[SAMPLE_W-1:0];
    endfunction

endpackage

[rtl/core/plucked_string_voice.sv]
// Top level of the plucked-string voice: delay line, sequencer and output stage.
//
// Input beats on s_*: opcode 0 writes one delay-line entry, opcode 1 plucks
// (seeds the previous output, rewinds the pointers, clears filter and count),
// opcode 2 produces one sample; opcode 3 is dropped. Only opcode 2 gives a beat
// on m_*.
// Load, pluck and dropped beats are taken while idle; s_tready stays high.
// A step beat passes from acceptance to the result in the output register
// through S_SUM for the pre-sum of the delay-line read, S_M1 to S_M3 for the
// gain product and S_F1 to S_F4 for the low-pass (alpha term, one-minus-alpha
// term, sum). s_tready stays low until the step leaves S_F4.
// The output register holds one result; loads and plucks are still taken
// while it waits. A step that finishes while m_tready is low waits in its last
// cycle until the register frees.
// Configuration writes on cfg_* are registered; write only while idle.
// Reset (aresetn low, synchronous) restores the register defaults, rewinds
// the pointers and clears filter, count and m_tvalid. Delay-line contents are
// not cleared and must be loaded before use.
`timescale 1ns / 1ps
module plucked_string_voice #(
    parameter int MAX_DELAY = psv_pkg::MAX_DELAY_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // opcode[1:0], position[13:2], value[29:14], zero fill
    input  logic [psv_pkg::S_TDATA_W-1:0]        s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // sample_out[15:0], samples_played[35:16], expired[36], zero fill
    output logic [psv_pkg::M_TDATA_W-1:0]        m_tdata,
    input  logic                                 cfg_wr_en,
    input  logic [psv_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [psv_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int LW = (AW + 1 > psv_pkg::DLEN_W) ? AW + 1 : psv_pkg::DLEN_W;
    localparam int SW = psv_pkg::SAMPLE_W;

    typedef enum logic [3:0] {
        S_IDLE, S_SUM, S_M1, S_M2, S_M3, S_F1, S_F2, S_F3, S_F4
    } state_t;

    state_t state_reg;

    logic [psv_pkg::DLEN_W-1:0]  dlen_reg;
    logic [psv_pkg::ALPHA_W-1:0] alpha_reg;
    logic [psv_pkg::COUNT_W-1:0] maxlen_reg;

    logic [AW-1:0]          rp_reg;
    logic [AW-1:0]          wp_reg;
    logic signed [SW-1:0]   last_reg;
    logic signed [SW-1:0]   fm_reg;
    logic [psv_pkg::COUNT_W-1:0] count_reg;
    logic signed [SW-1:0]   cur_reg;
    logic signed [psv_pkg::MAC_A_W-1:0] sum_reg;
    logic signed [SW-1:0]   mix_reg;

    logic                   m_tvalid_reg;
    logic signed [SW-1:0]   out_sample_reg;
    logic [psv_pkg::COUNT_W-1:0] out_count_reg;
    logic                   out_expired_reg;

    logic signed [SW-1:0]   mem [MAX_DELAY];
    logic signed [SW-1:0]   rdata_reg;
    logic                   mem_we;
    logic [AW-1:0]          mem_addr;
    logic signed [SW-1:0]   mem_wdata;

    logic [psv_pkg::OP_W-1:0]  in_op;
    logic [psv_pkg::POS_W-1:0] in_pos;
    logic signed [SW-1:0]      in_value;
    logic [LW-1:0]             pos_ext;
    logic                      in_fire;
    logic                      out_free;

    logic [LW-1:0]          dlen_ext;
    logic [LW-1:0]          len;
    logic [LW-1:0]          rp_inc;
    logic [LW-1:0]          wp_inc;
    logic [AW-1:0]          rp_next;
    logic [AW-1:0]          wp_next;
    logic [psv_pkg::COUNT_W-1:0] count_next;
    logic signed [psv_pkg::MAC_A_W-1:0] sum_next;
    logic signed [SW-1:0]   y;
    logic signed [SW-1:0]   mix_sat;

    psv_pkg::psv_mac_ctrl_t                mac_ctrl;
    logic signed [psv_pkg::MAC_A_W-1:0]    mac_a;
    logic signed [psv_pkg::MAC_B_W-1:0]    mac_b;
    logic signed [psv_pkg::ACC_W-1:0]      mac_bias;
    logic signed [psv_pkg::ACC_W-1:0]      mac_acc;

    assign in_op    = s_tdata[1:0];
    assign in_pos   = s_tdata[13:2];
    assign in_value = s_tdata[29:14];
    assign pos_ext  = LW'(in_pos);

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_expired_reg, out_count_reg, out_sample_reg};

    // effective delay length, clamped to [2, MAX_DELAY]
    assign dlen_ext = LW'(dlen_reg);
    always_comb begin
        if (dlen_ext < LW'(2)) begin
            len = LW'(2);
        end else if (dlen_ext > LW'(MAX_DELAY)) begin
            len = LW'(MAX_DELAY);
        end else begin
            len = dlen_ext;
        end
    end

    assign rp_inc  = LW'(rp_reg) + LW'(1);
    assign wp_inc  = LW'(wp_reg) + LW'(1);
    assign rp_next = (rp_inc >= len) ? '0 : rp_inc[AW-1:0];
    assign wp_next = (wp_inc >= len) ? '0 : wp_inc[AW-1:0];

    assign count_next = (count_reg == psv_pkg::COUNT_MAX) ? count_reg
                                                          : count_reg + 1'b1;

    assign sum_next = psv_pkg::MAC_A_W'(last_reg) + psv_pkg::MAC_A_W'(rdata_reg)
                    + (psv_pkg::MAC_A_W'(rdata_reg) <<< 1);

    assign mix_sat = psv_pkg::sat_sample(mac_acc >>> 18);
    assign y       = psv_pkg::sat_sample(mac_acc >>> 16);

    always_comb begin
        mac_ctrl = '0;
        mac_a    = '0;
        mac_b    = '0;
        mac_bias = '0;
        case (state_reg)
            S_M1: begin
                mac_ctrl.mul_en = 1'b1;
                mac_a = sum_reg;
                mac_b = $signed(psv_pkg::GAIN_Q16);
            end
            S_M2: begin
                mac_ctrl.acc_clear = 1'b1;
                mac_bias = $signed(psv_pkg::MIX_BIAS);
            end
            S_F1: begin
                mac_ctrl.mul_en = 1'b1;
                mac_a = psv_pkg::MAC_A_W'(mix_reg);
                mac_b = $signed(psv_pkg::MAC_B_W'(alpha_reg));
            end
            S_F2: begin
                mac_ctrl.mul_en    = 1'b1;
                mac_ctrl.acc_clear = 1'b1;
                mac_a    = psv_pkg::MAC_A_W'(fm_reg);
                mac_b    = $signed(psv_pkg::UNITY_Q16 - psv_pkg::MAC_B_W'(alpha_reg));
                mac_bias = $signed(psv_pkg::FILT_BIAS);
            end
            S_F3: begin
                mac_ctrl.acc_add = 1'b1;
            end
            default: begin
                mac_ctrl = '0;
            end
        endcase
    end

    psv_mac u_mac (
        .aclk   (aclk),
        .ctrl_i (mac_ctrl),
        .a_i    (mac_a),
        .b_i    (mac_b),
        .bias_i (mac_bias),
        .acc_o  (mac_acc)
    );

    // single write port: loads while idle, feedback at the end of a step
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = wp_reg;
        mem_wdata = y;
        if (in_fire && in_op == psv_pkg::OP_LOAD && pos_ext < LW'(MAX_DELAY)) begin
            mem_we    = 1'b1;
            mem_addr  = pos_ext[AW-1:0];
            mem_wdata = in_value;
        end else if (state_reg == S_F4 && out_free) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= mem[rp_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            dlen_reg     <= psv_pkg::DLEN_RESET;
            alpha_reg    <= psv_pkg::ALPHA_RESET;
            maxlen_reg   <= psv_pkg::MAXLEN_RESET;
            rp_reg       <= AW'(1);
            wp_reg       <= '0;
            last_reg     <= '0;
            fm_reg       <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    psv_pkg::REG_DELAY_LENGTH:    dlen_reg   <= cfg_wdata[psv_pkg::DLEN_W-1:0];
                    psv_pkg::REG_SMOOTHING_ALPHA: alpha_reg  <= cfg_wdata[psv_pkg::ALPHA_W-1:0];
                    psv_pkg::REG_MAX_NOTE_LENGTH: maxlen_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            // a finishing step reloads the register in the same cycle
            if (m_tvalid_reg && m_tready && state_reg != S_F4) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        case (in_op)
                            psv_pkg::OP_PLUCK: begin
                                last_reg  <= in_value;
                                rp_reg    <= AW'(1);
                                wp_reg    <= '0;
                                fm_reg    <= '0;
                                count_reg <= '0;
                            end
                            psv_pkg::OP_STEP: state_reg <= S_SUM;
                            default: ;
                        endcase
                    end
                end
                S_SUM: begin
                    cur_reg   <= rdata_reg;
                    sum_reg   <= sum_next;
                    state_reg <= S_M1;
                end
                S_M1: state_reg <= S_M2;
                S_M2: state_reg <= S_M3;
                S_M3: begin
                    mix_reg   <= mix_sat;
                    state_reg <= S_F1;
                end
                S_F1: state_reg <= S_F2;
                S_F2: state_reg <= S_F3;
                S_F3: state_reg <= S_F4;
                S_F4: begin
                    if (out_free) begin
                        fm_reg          <= y;
                        last_reg        <= cur_reg;
                        rp_reg          <= rp_next;
                        wp_reg          <= wp_next;
                        count_reg       <= count_next;
                        out_sample_reg  <= cur_reg;
                        out_count_reg   <= count_next;
                        out_expired_reg <= (count_next > maxlen_reg);
                        m_tvalid_reg    <= 1'b1;
                        state_reg       <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/core/psv_mac.sv]
// Shared multiply-accumulate unit: registered product, then accumulator.
`timescale 1ns / 1ps
module psv_mac (
    input  logic                                 aclk,
    input  psv_pkg::psv_mac_ctrl_t               ctrl_i,
    input  logic signed [psv_pkg::MAC_A_W-1:0]   a_i,
    input  logic signed [psv_pkg::MAC_B_W-1:0]   b_i,
    input  logic signed [psv_pkg::ACC_W-1:0]     bias_i,
    output logic signed [psv_pkg::ACC_W-1:0]     acc_o
);

    logic signed [psv_pkg::PROD_W-1:0] prod_reg;
    logic signed [psv_pkg::PROD_W-1:0] prod_next;
    logic signed [psv_pkg::ACC_W-1:0]  prod_ext;
    logic signed [psv_pkg::ACC_W-1:0]  acc_reg;

    assign prod_next = a_i * b_i;
    assign prod_ext  = psv_pkg::ACC_W'(prod_reg);
    assign acc_o     = acc_reg;

    always_ff @(posedge aclk) begin
        if (ctrl_i.mul_en) begin
            prod_reg <= prod_next;
        end
        if (ctrl_i.acc_clear) begin
            acc_reg <= bias_i + prod_ext;
        end else if (ctrl_i.acc_add) begin
            acc_reg <= acc_reg + prod_ext;
        end
    end

endmodule

[rtl/core/psv_checker.sv]
// Port-level assertions for the plucked-string voice, bound to the top level.
`timescale 1ns / 1ps
module psv_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [psv_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [psv_pkg::M_TDATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat present after reset");

    a_step_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata[1:0] == psv_pkg::OP_STEP |=> !s_tready)
        else $error("step beat did not make the voice busy");

    a_other_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata[1:0] != psv_pkg::OP_STEP |=> s_tready)
        else $error("load or pluck beat stalled the input");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[35:16] != 20'd0)
        else $error("result beat with zero sample count");

endmodule

bind plucked_string_voice psv_checker u_psv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
